### hdl/fjq_pkg.sv
// Shared types, codes and the control store of the FIFO job queue.
package fjq_pkg;

	typedef struct packed {
		logic        opcode;
		logic [15:0] job_id;
		logic [31:0] arrival_time;
		logic [31:0] run_length;
		logic [31:0] deadline;
	} fjq_in_t;

	typedef struct packed {
		logic [15:0] job_id_res;
		logic        aborted;
		logic [32:0] event_time;
		logic [32:0] wait_delay;
		logic        last;
	} fjq_out_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] arr;
		logic [31:0] len;
		logic [31:0] dead;
	} fjq_entry_t;

	localparam logic OP_JOB   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int        CFG_AW          = 3;
	localparam logic      CFG_QUEUE_LIMIT = 1'b0;
	localparam logic [3:0] RESET_LIMIT    = 4'd3;

	localparam logic [3:0] A_NONE    = 4'd0;
	localparam logic [3:0] A_TAKE    = 4'd1;
	localparam logic [3:0] A_READ    = 4'd2;
	localparam logic [3:0] A_FIN     = 4'd3;
	localparam logic [3:0] A_CMP     = 4'd4;
	localparam logic [3:0] A_UPD     = 4'd5;
	localparam logic [3:0] A_EMIT_SV = 4'd6;
	localparam logic [3:0] A_START   = 4'd7;
	localparam logic [3:0] A_ENQ     = 4'd8;
	localparam logic [3:0] A_REJECT  = 4'd9;

	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_NO_IN    = 3'd2;
	localparam logic [2:0] C_FLUSH    = 3'd3;
	localparam logic [2:0] C_ARR_LT   = 3'd4;
	localparam logic [2:0] C_OCC_ZERO = 3'd5;
	localparam logic [2:0] C_OCC_FULL = 3'd6;
	localparam logic [2:0] C_OUT_BUSY = 3'd7;

	localparam int         N_STEPS  = 19;
	localparam logic [4:0] S_WAIT   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_ARR    = 5'd2;
	localparam logic [4:0] S_ARR2   = 5'd3;
	localparam logic [4:0] S_RD     = 5'd4;
	localparam logic [4:0] S_FIN    = 5'd5;
	localparam logic [4:0] S_CMP    = 5'd6;
	localparam logic [4:0] S_UPD    = 5'd7;
	localparam logic [4:0] S_EMS    = 5'd8;
	localparam logic [4:0] S_EMS2   = 5'd9;
	localparam logic [4:0] S_EMS3   = 5'd10;
	localparam logic [4:0] S_START  = 5'd11;
	localparam logic [4:0] S_START2 = 5'd12;
	localparam logic [4:0] S_PLACE  = 5'd13;
	localparam logic [4:0] S_ENQ    = 5'd14;
	localparam logic [4:0] S_REJ    = 5'd15;
	localparam logic [4:0] S_REJ2   = 5'd16;
	localparam logic [4:0] S_FLCHK  = 5'd17;
	localparam logic [4:0] S_FLCHK2 = 5'd18;

	typedef struct packed {
		logic [3:0] act;
		logic [2:0] cond;
		logic [4:0] target;
	} fjq_uword_t;

	typedef struct packed {
		logic no_in;
		logic flush;
		logic arr_lt;
		logic occ_zero;
		logic occ_full;
		logic out_busy;
	} fjq_stat_t;

	function automatic fjq_uword_t fjq_rom(input logic [4:0] step);
		fjq_uword_t uw;
		case (step)
			S_WAIT:   uw = {A_TAKE,    C_NO_IN,    S_WAIT};
			S_DISP:   uw = {A_NONE,    C_FLUSH,    S_FLCHK};
			S_ARR:    uw = {A_NONE,    C_ARR_LT,   S_PLACE};
			S_ARR2:   uw = {A_NONE,    C_OCC_ZERO, S_START};
			S_RD:     uw = {A_READ,    C_NEVER,    S_WAIT};
			S_FIN:    uw = {A_FIN,     C_NEVER,    S_WAIT};
			S_CMP:    uw = {A_CMP,     C_NEVER,    S_WAIT};
			S_UPD:    uw = {A_UPD,     C_NEVER,    S_WAIT};
			S_EMS:    uw = {A_EMIT_SV, C_OUT_BUSY, S_EMS};
			S_EMS2:   uw = {A_NONE,    C_FLUSH,    S_FLCHK};
			S_EMS3:   uw = {A_NONE,    C_ALWAYS,   S_ARR};
			S_START:  uw = {A_START,   C_OUT_BUSY, S_START};
			S_START2: uw = {A_NONE,    C_ALWAYS,   S_WAIT};
			S_PLACE:  uw = {A_NONE,    C_OCC_FULL, S_REJ};
			S_ENQ:    uw = {A_ENQ,     C_ALWAYS,   S_WAIT};
			S_REJ:    uw = {A_REJECT,  C_OUT_BUSY, S_REJ};
			S_REJ2:   uw = {A_NONE,    C_ALWAYS,   S_WAIT};
			S_FLCHK:  uw = {A_NONE,    C_OCC_ZERO, S_WAIT};
			S_FLCHK2: uw = {A_NONE,    C_ALWAYS,   S_RD};
			default:  uw = {A_NONE,    C_ALWAYS,   S_WAIT};
		endcase
		return uw;
	endfunction

endpackage

### hdl/fjq_useq.sv
// Microprogram sequencer: step counter, control store and jump logic.
module fjq_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  fjq_pkg::fjq_stat_t stat,
	output logic [3:0]       act,
	output logic             at_wait
);
	import fjq_pkg::*;

	logic [4:0] upc_q;
	fjq_uword_t uw;
	logic       jump;

	assign uw      = fjq_rom(upc_q);
	assign act     = uw.act;
	assign at_wait = (upc_q == S_WAIT);

	always_comb begin
		case (uw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_IN:    jump = stat.no_in;
			C_FLUSH:    jump = stat.flush;
			C_ARR_LT:   jump = stat.arr_lt;
			C_OCC_ZERO: jump = stat.occ_zero;
			C_OCC_FULL: jump = stat.occ_full;
			C_OUT_BUSY: jump = stat.out_busy;
			default:    jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_WAIT;
		end else if (jump) begin
			upc_q <= uw.target;
		end else begin
			upc_q <= upc_q + 5'd1;
		end
	end

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q < 5'(N_STEPS))
		else $error("Step counter left the program.");

endmodule

### hdl/fjq_dp.sv
// Datapath: queue memory, server time, queue pointers and the result register.
module fjq_dp #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        act,
	input  logic              job_valid,
	input  fjq_pkg::fjq_in_t  job,
	input  logic [3:0]        queue_limit,
	input  logic              res_stall,
	output logic              res_valid,
	output fjq_pkg::fjq_out_t res,
	output fjq_pkg::fjq_stat_t stat
);
	import fjq_pkg::*;

	localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W  = $clog2(DEPTH + 1);
	localparam int SW     = OCC_W + 1;
	localparam int CW     = (OCC_W > 4) ? OCC_W : 4;

	fjq_entry_t        mem [DEPTH];
	fjq_in_t           job_q;
	fjq_entry_t        ent_q;
	logic [33:0]       fin_q;
	logic              late_q;
	logic              early_q;
	logic              ab_q;
	logic [32:0]       ev_q;
	logic [32:0]       dl_q;
	logic [32:0]       sft_q;
	logic [HEAD_W-1:0] head_q;
	logic [OCC_W-1:0]  occ_q;
	logic              res_valid_q;
	fjq_out_t          res_q;

	logic [HEAD_W-1:0] head_nxt;
	logic [SW-1:0]     sum_w;
	logic [SW-1:0]     tail_w;
	logic [HEAD_W-1:0] tail;
	logic [CW-1:0]     lim_ext;
	logic [CW-1:0]     lim_eff;
	logic [32:0]       dead33;
	logic [32:0]       minuend;
	logic [32:0]       start_ev;
	logic              out_free;
	logic              emit;
	logic              last_sv;

	assign head_nxt = (head_q == HEAD_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign sum_w    = SW'(head_q) + SW'(occ_q);
	assign tail_w   = (sum_w >= SW'(DEPTH)) ? sum_w - SW'(DEPTH) : sum_w;
	assign tail     = tail_w[HEAD_W-1:0];
	assign lim_ext  = CW'(queue_limit);
	assign lim_eff  = (lim_ext > CW'(DEPTH)) ? CW'(DEPTH) : lim_ext;
	assign dead33   = {1'b0, ent_q.dead};
	assign minuend  = (late_q && early_q) ? dead33 : sft_q;
	assign start_ev = {1'b0, job_q.arrival_time} + {1'b0, job_q.run_length};
	assign out_free = !res_valid_q || !res_stall;
	assign emit     = (act == A_EMIT_SV) || (act == A_START) || (act == A_REJECT);

	assign stat.no_in    = !job_valid;
	assign stat.flush    = (job_q.opcode == OP_FLUSH);
	assign stat.arr_lt   = ({1'b0, job_q.arrival_time} < sft_q);
	assign stat.occ_zero = (occ_q == '0);
	assign stat.occ_full = (CW'(occ_q) >= lim_eff);
	assign stat.out_busy = !out_free;

	assign last_sv = stat.flush ? stat.occ_zero : (stat.arr_lt && !stat.occ_full);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (act == A_ENQ) begin
			mem[tail] <= {job_q.job_id, job_q.arrival_time, job_q.run_length,
				job_q.deadline};
		end
		if (act == A_READ) begin
			ent_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (act == A_TAKE && job_valid) begin
			job_q <= job;
		end
		if (act == A_FIN) begin
			fin_q <= {1'b0, sft_q} + {2'b0, ent_q.len};
		end
		if (act == A_CMP) begin
			late_q  <= (fin_q > {1'b0, dead33});
			early_q <= (sft_q < dead33);
		end
		if (act == A_UPD) begin
			ab_q <= late_q;
			ev_q <= late_q ? minuend : fin_q[32:0];
			dl_q <= minuend - {1'b0, ent_q.arr};
		end
		if (emit && out_free) begin
			case (act)
				A_EMIT_SV: res_q <= {ent_q.id, ab_q, ev_q, dl_q, last_sv};
				A_START:   res_q <= {job_q.job_id, 1'b0, start_ev, 33'd0, 1'b1};
				default:   res_q <= {job_q.job_id, 1'b1, {1'b0, job_q.arrival_time},
					33'd0, 1'b1};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sft_q       <= '0;
			head_q      <= '0;
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (act == A_UPD) begin
				if (late_q && early_q) begin
					sft_q <= dead33;
				end else if (!late_q) begin
					sft_q <= fin_q[32:0];
				end
				head_q <= head_nxt;
				occ_q  <= occ_q - 1'b1;
			end
			if (act == A_START && out_free) begin
				sft_q <= start_ev;
			end
			if (act == A_ENQ) begin
				occ_q <= occ_q + 1'b1;
			end
			if (emit && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("Queue occupancy exceeds the queue depth.");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= HEAD_W'(DEPTH - 1))
		else $error("Head pointer outside the queue.");

	a_sft_mono: assert property (@(posedge clk) disable iff (!arst_n)
		sft_q >= $past(sft_q))
		else $error("Server free time moved backward.");

endmodule

### hdl/fifo_job_queue_with_timeouts.sv
// Top level of the FIFO job queue with timeouts: configuration port and core.
// A job is accepted only in the wait step of the microprogram; job_stall is high while the
// steps for the last job run: starting it at once, rejecting it or queueing it, and serving
// each queued job while the server frees before its arrival; a flush serves every queued job.
// An output stall holds the steps that emit a result, and so holds back the next acceptance.
// Reset is asynchronous: queue empty, server free at time zero, queue_limit 3.
module fifo_job_queue_with_timeouts #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_stall,
	input  fjq_pkg::fjq_in_t           job,
	output logic                       res_valid,
	input  logic                       res_stall,
	output fjq_pkg::fjq_out_t          res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fjq_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import fjq_pkg::*;

	logic [3:0] queue_limit_q;
	logic [3:0] act;
	logic       at_wait;
	fjq_stat_t  stat;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == CFG_QUEUE_LIMIT) ? {28'd0, queue_limit_q} : 32'd0;
	assign job_stall = !at_wait;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= RESET_LIMIT;
		end else if (psel && penable && pwrite && paddr[2] == CFG_QUEUE_LIMIT) begin
			queue_limit_q <= pwdata[3:0];
		end
	end

	fjq_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (stat),
		.act     (act),
		.at_wait (at_wait)
	);

	fjq_dp #(
		.DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.act         (act),
		.job_valid   (job_valid),
		.job         (job),
		.queue_limit (queue_limit_q),
		.res_stall   (res_stall),
		.res_valid   (res_valid),
		.res         (res),
		.stat        (stat)
	);

endmodule

### dv/tb_fifo_job_queue_with_timeouts.sv
// Testbench for the FIFO job queue with timeouts: directed and random jobs checked against a scheduler model.
module tb_fifo_job_queue_with_timeouts;
	import fjq_pkg::*;

	localparam int QUEUE_DEPTH = 8;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int REG_STRIDE = 4;
	localparam int ITEMS_PER_PHASE = 50;
	localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'(REG_STRIDE * CFG_QUEUE_LIMIT);

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               job_valid = 1'b0;
	logic               job_stall;
	fjq_in_t            job = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	fjq_out_t           res;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [CFG_AW-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	fjq_entry_t         ring [QUEUE_DEPTH];
	logic [2:0]         ring_head = '0;
	logic [3:0]         ring_count = '0;
	logic [32:0]        server_free_at = '0;
	logic [3:0]         limit_reg = RESET_LIMIT;
	logic [31:0]        arrival_base = '0;
	fjq_out_t           pending_records [$];
	int                 fail_count = 0;
	int                 hold_request = 0;
	bit                 sender_idles = 1'b1;
	bit                 receiver_idles = 1'b1;

	fifo_job_queue_with_timeouts #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job(job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic fjq_out_t serve_queue_head();
		fjq_entry_t  e;
		logic [33:0] finish_at;
		fjq_out_t    r;
		e = ring[ring_head];
		finish_at = {1'b0, server_free_at} + {2'b0, e.len};
		r.job_id_res = e.id;
		r.last = 1'b0;
		if (finish_at > {2'b0, e.dead}) begin
			if (server_free_at < {1'b0, e.dead})
				server_free_at = {1'b0, e.dead};
			r.aborted = 1'b1;
			r.event_time = server_free_at;
			r.wait_delay = server_free_at - {1'b0, e.arr};
		end else begin
			r.aborted = 1'b0;
			r.event_time = finish_at[32:0];
			r.wait_delay = server_free_at - {1'b0, e.arr};
			server_free_at = finish_at[32:0];
		end
		ring_head = ring_head + 3'd1;
		ring_count = ring_count - 4'd1;
		return r;
	endfunction

	function automatic void expect_record(input fjq_out_t r);
		pending_records = {pending_records, r};
	endfunction

	function automatic void schedule_item(input fjq_in_t it);
		fjq_out_t   r;
		fjq_entry_t e;
		logic [3:0] room;
		logic [2:0] tail;
		bit         started;
		int         n_recs;
		started = 1'b0;
		n_recs = 0;
		if (it.opcode == OP_FLUSH) begin
			while (ring_count != 0) begin
				expect_record(serve_queue_head());
				n_recs++;
			end
		end else begin
			while (!started && {1'b0, it.arrival_time} >= server_free_at) begin
				if (ring_count != 0) begin
					expect_record(serve_queue_head());
					n_recs++;
				end else begin
					server_free_at = {1'b0, it.arrival_time} + {1'b0, it.run_length};
					r.job_id_res = it.job_id;
					r.aborted = 1'b0;
					r.event_time = server_free_at;
					r.wait_delay = '0;
					r.last = 1'b0;
					expect_record(r);
					n_recs++;
					started = 1'b1;
				end
			end
			if (!started) begin
				room = (limit_reg > QUEUE_DEPTH) ? 4'(QUEUE_DEPTH) : limit_reg;
				if (ring_count < room) begin
					tail = ring_head + ring_count[2:0];
					e.id = it.job_id;
					e.arr = it.arrival_time;
					e.len = it.run_length;
					e.dead = it.deadline;
					ring[tail] = e;
					ring_count = ring_count + 4'd1;
				end else begin
					r.job_id_res = it.job_id;
					r.aborted = 1'b1;
					r.event_time = {1'b0, it.arrival_time};
					r.wait_delay = '0;
					r.last = 1'b0;
					expect_record(r);
					n_recs++;
				end
			end
		end
		if (n_recs != 0) begin
			r = pending_records[pending_records.size() - 1];
			r.last = 1'b1;
			pending_records[pending_records.size() - 1] = r;
		end
	endfunction

	function automatic void compare_field(input string name, input logic [32:0] want,
		input logic [32:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_record(input fjq_out_t got);
		fjq_out_t want;
		if (pending_records.size() == 0) begin
			$error("record for job %0d arrived with none pending", got.job_id_res);
			fail_count++;
		end else begin
			want = pending_records.pop_front();
			compare_field("job_id_res", want.job_id_res, got.job_id_res);
			compare_field("aborted", want.aborted, got.aborted);
			compare_field("event_time", want.event_time, got.event_time);
			compare_field("wait_delay", want.wait_delay, got.wait_delay);
			compare_field("last", want.last, got.last);
		end
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				check_record(res);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left != 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input fjq_in_t it);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			job_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		job <= it;
		job_valid <= 1'b1;
		@(posedge clk);
		while (job_stall)
			@(posedge clk);
		schedule_item(it);
	endtask

	task automatic wait_drained();
		job_valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {28'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		limit_reg = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		compare_field("queue_limit", {29'b0, value}, {1'b0, prdata});
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic fjq_in_t job_item(input logic [15:0] id, input logic [31:0] arr,
		input logic [31:0] len, input logic [31:0] dead);
		fjq_in_t it;
		it.opcode = OP_JOB;
		it.job_id = id;
		it.arrival_time = arr;
		it.run_length = len;
		it.deadline = dead;
		return it;
	endfunction

	function automatic fjq_in_t flush_item();
		fjq_in_t it;
		it.opcode = OP_FLUSH;
		it.job_id = 16'($urandom);
		it.arrival_time = $urandom;
		it.run_length = $urandom;
		it.deadline = $urandom;
		return it;
	endfunction

	function automatic logic [31:0] next_start();
		logic [31:0] t;
		t = (arrival_base > server_free_at[31:0]) ? arrival_base : server_free_at[31:0];
		return t + 32'd10;
	endfunction

	function automatic fjq_in_t random_item();
		fjq_in_t it;
		bit      long_job;
		it = flush_item();
		if ($urandom_range(0, 11) == 0)
			return it;
		it.opcode = OP_JOB;
		long_job = 1'b0;
		if ($urandom_range(0, 19) == 0 && arrival_base < 32'hE000_0000)
			arrival_base = arrival_base + $urandom_range(0, 1 << 26);
		else
			arrival_base = arrival_base + $urandom_range(0, 12);
		it.arrival_time = arrival_base;
		case ($urandom_range(0, 9))
			0: it.run_length = '0;
			1: begin
				// A very long job is only offered when it cannot start at once.
				if ({1'b0, arrival_base} < server_free_at) begin
					it.run_length = $urandom | 32'h8000_0000;
					long_job = 1'b1;
				end else begin
					it.run_length = $urandom_range(1, 40);
				end
			end
			default: it.run_length = $urandom_range(1, 40);
		endcase
		case ($urandom_range(0, 7))
			0: it.deadline = '1;
			1: it.deadline = $urandom;
			2: it.deadline = arrival_base - $urandom_range(0, 5);
			default: it.deadline = arrival_base + $urandom_range(0, 120);
		endcase
		if (long_job)
			it.deadline = arrival_base + $urandom_range(0, 120);
		return it;
	endfunction

	task automatic test_default_limit();
		send_item(job_item(16'd1, 32'd0, 32'd10, 32'd100));
		send_item(job_item(16'd2, 32'd1, 32'd5, 32'd100));
		send_item(job_item(16'd3, 32'd2, 32'd5, 32'd12));
		send_item(job_item(16'd4, 32'd3, 32'd20, 32'd30));
		send_item(job_item(16'd5, 32'd4, 32'd7, 32'd50));
		send_item(job_item(16'd6, 32'd100, 32'd0, 32'd0));
		send_item(job_item(16'd7, 32'd100, 32'd0, 32'd0));
		arrival_base = 32'd100;
		wait_drained();
	endtask

	task automatic test_flush();
		logic [31:0] t0;
		t0 = next_start();
		send_item(flush_item());
		send_item(job_item(16'd8, t0, 32'd50, t0 + 32'd200));
		send_item(job_item(16'd9, t0 + 32'd1, 32'd5, t0 + 32'd1000));
		send_item(job_item(16'd10, t0 + 32'd2, 32'd100, t0 + 32'd60));
		send_item(flush_item());
		send_item(flush_item());
		arrival_base = t0 + 32'd2;
		wait_drained();
	endtask

	task automatic test_limit_extremes();
		logic [31:0] t0;
		write_limit(4'd0);
		t0 = next_start();
		send_item(job_item(16'd11, t0, 32'd50, t0));
		send_item(job_item(16'd12, t0 + 32'd1, 32'd5, t0 + 32'd100));
		arrival_base = t0 + 32'd1;
		wait_drained();
		write_limit(4'hF);
		t0 = next_start();
		send_item(job_item(16'd13, t0, 32'd1000, t0));
		for (int k = 1; k <= QUEUE_DEPTH + 1; k++)
			send_item(job_item(16'(13 + k), t0 + 32'(k), 32'd10, t0 + 32'd1040));
		send_item(job_item(16'd23, t0 + 32'd2000, 32'd3, t0 + 32'd2000));
		arrival_base = t0 + 32'd2000;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_limit(4'd1);
				1: write_limit(4'd8);
				2: write_limit(4'($urandom_range(2, 7)));
				default: begin
					sender_idles = 1'b0;
					receiver_idles = 1'b0;
					write_limit(RESET_LIMIT);
				end
			endcase
			if (phase == 2)
				hold_request = HOLD_CYCLES;
			repeat (ITEMS_PER_PHASE) send_item(random_item());
			wait_drained();
		end
	endtask

	task automatic test_extreme_fields();
		logic [31:0] t0;
		t0 = next_start();
		send_item(job_item(16'h0000, t0, 32'd0, 32'd0));
		send_item(job_item(16'hFFFF, t0, '1, '1));
		send_item(job_item(16'h1234, '1, '1, '1));
		send_item(job_item(16'hABCD, '1, 32'd1, 32'd0));
		send_item(flush_item());
		arrival_base = '1;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_limit();
		test_flush();
		test_limit_extremes();
		test_random_traffic();
		test_extreme_fields();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/fjq_pkg.sv
hdl/fjq_useq.sv
hdl/fjq_dp.sv
hdl/fifo_job_queue_with_timeouts.sv
dv/tb_fifo_job_queue_with_timeouts.sv
